@@ hdl/binary_cross_entropy_gradient_defines.svh @@
// Assertion macros shared by the binary cross-entropy gradient RTL.
`ifndef BINARY_CROSS_ENTROPY_GRADIENT_DEFINES_SVH
`define BINARY_CROSS_ENTROPY_GRADIENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BCE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bce assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bce assertion failed");

`endif

@@ hdl/bce_pkg.sv @@
// Shared constants, log2 table and pipeline types of the BCE gradient block.
package bce_pkg;

   localparam int LOG_TABLE_SIZE = 256;
   localparam int LOG_AW = $clog2(LOG_TABLE_SIZE + 1);
   localparam int QUO_BITS = 33;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef logic [24:0] log_tab_type [0:LOG_TABLE_SIZE];

   // T[i] = log2(1 + i/SIZE) in Q1.24 by repeated squaring, truncated.
   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] y;
      logic [24:0] acc;
      for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
         y = ((64'(LOG_TABLE_SIZE) + 64'(i)) << 30) / LOG_TABLE_SIZE;
         acc = '0;
         for (int b = 0; b < 24; b++) begin
            y = (y * y) >> 30;
            acc = acc << 1;
            if (y >= 64'h8000_0000) begin
               acc = acc | 25'd1;
               y = y >> 1;
            end
         end
         tab[i] = acc;
      end
      tab[LOG_TABLE_SIZE] = 25'h100_0000;
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();

   // Data that rides along the divider chain untouched.
   typedef struct packed {
      logic        valid;
      logic        pneg;
      logic        gneg;
      logic        gzero;
      logic        pzero;
      logic        lzero;
      logic [31:0] gl;
      logic        glsat;
   } pass_type;

   typedef struct packed {
      pass_type              pass;
      logic [30:0]           rem;
      logic [QUO_BITS-1:0]   nb;
      logic [QUO_BITS-1:0]   quo;
      logic [30:0]           den;
      logic                  ovf;
   } div_stage_type;

endpackage

@@ hdl/binary_cross_entropy_gradient.sv @@
// Top level of the fixed-point binary cross-entropy gradient pipeline.
//
// Channel   Direction  Ports                                  Handshake
// request   in         req_prob, req_label, req_upstream_grad start && !busy
// response  out        rsp_grad_prob, rsp_grad_label,         rsp_valid strobe
//                      rsp_saturated
//
// One transaction can be accepted in every cycle; busy is always low.
// Each result is on the rsp_ ports for one cycle; the 33-cell divider chain
// makes up most of the pipeline between request and response.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`include "binary_cross_entropy_gradient_defines.svh"

module binary_cross_entropy_gradient (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [15:0] req_prob,
   input  logic        [15:0] req_label,
   input  logic signed [31:0] req_upstream_grad,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_grad_prob,
   output logic signed [31:0] rsp_grad_label,
   output logic               rsp_saturated
);

   localparam int LATENCY = bce_pkg::QUO_BITS + 8;

   // Front-end pipeline record; later stages reuse fields as they go.
   typedef struct packed {
      logic        valid;
      logic        gneg;
      logic        gzero;
      logic        dneg;
      logic        pzero;
      logic        lzero;
      logic        lneg;
      logic [31:0] gmag;
      logic [30:0] den;
      logic [63:0] n;
      logic [60:0] acc;
      logic [31:0] gl;
      logic        glsat;
   } pipe_type;

   // Saturate a sign and magnitude to a 32-bit result; bit 32 marks clipping.
   function automatic logic [32:0] sat(input logic neg, input logic [39:0] mag);
      logic [32:0] res;
      if (neg) begin
         if (mag > 40'h80000000) res = {1'b1, 32'h80000000};
         else res = {1'b0, 32'(~mag[31:0] + 32'd1)};
      end else begin
         if (mag > 40'h7FFFFFFF) res = {1'b1, 32'h7FFFFFFF};
         else res = {1'b0, mag[31:0]};
      end
      return res;
   endfunction

   logic        v1_ff;
   logic [15:0] p1_ff, l1_ff;
   logic [31:0] g1_ff;

   pipe_type s2_in, s3_in, s4_in, s5_in, s6_in, s7_in;
   pipe_type s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;

   logic [16:0] q1;
   logic [32:0] pq;
   logic [15:0] dmag;
   logic [28:0] logp, logq, lmag;
   logic [28:0] nat;
   logic [36:0] glmag;
   logic [32:0] gl_sat;

   bce_pkg::div_stage_type chain [0:bce_pkg::QUO_BITS];
   bce_pkg::div_stage_type div_out;

   logic        out_valid_ff;
   logic [31:0] gp_ff, gl_ff;
   logic        sat_ff;
   logic [31:0] gp_fin, gl_fin;
   logic        sat_fin;
   logic [32:0] gp_sat;

   // Request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      p1_ff <= req_prob;
      l1_ff <= req_label;
      g1_ff <= req_upstream_grad;
   end

   assign q1 = 17'h10000 - {1'b0, p1_ff};

   bce_log2 u_log_p (.clock(clock), .x({1'b0, p1_ff}), .log_q24(logp));
   bce_log2 u_log_q (.clock(clock), .x(q1), .log_q24(logq));

   // The front end splits the signs off, forms the divider operands and the
   // natural-log product while the two log2 units run in parallel.
   always_comb begin
      s2_in = '0;
      s2_in.valid = v1_ff;
      s2_in.gneg = g1_ff[31];
      s2_in.gmag = g1_ff[31] ? (~g1_ff + 32'd1) : g1_ff;
      s2_in.gzero = g1_ff == 32'd0;
      s2_in.dneg = l1_ff > p1_ff;
      s2_in.pzero = p1_ff == 16'd0;
      s2_in.lzero = l1_ff == 16'd0;
      dmag = (l1_ff > p1_ff) ? (l1_ff - p1_ff) : (p1_ff - l1_ff);
      pq = 33'(p1_ff) * 33'(q1);
      s2_in.den = pq[30:0];
      s2_in.n = 64'(48'(dmag) * 48'(s2_in.gmag));

      // Numerator with half the divisor added for round to nearest.
      s3_in = s2_ff;
      s3_in.n = {s2_ff.n[47:0], 16'd0} + 64'(s2_ff.den >> 1);

      s4_in = s3_ff;

      // Log difference times ln2; the log2 results line up with this stage.
      s5_in = s4_ff;
      s5_in.lneg = logp > logq;
      lmag = (logp > logq) ? (logp - logq) : (logq - logp);
      s5_in.acc = 61'(lmag) * 61'(bce_pkg::LN2_Q32);

      s6_in = s5_ff;
      nat = 29'((s5_ff.acc + 61'h8000_0000) >> 32);
      s6_in.acc = 61'(nat) * 61'(s5_ff.gmag);

      s7_in = s6_ff;
      glmag = 37'((s6_ff.acc + 61'h80_0000) >> 24);
      gl_sat = sat(s6_ff.lneg != s6_ff.gneg, 40'(glmag));
      s7_in.gl = gl_sat[31:0];
      s7_in.glsat = gl_sat[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   // Divider chain entry. A quotient that needs more than 33 bits is flagged
   // up front and saturates at the end.
   always_comb begin
      chain[0].pass.valid = s7_ff.valid;
      chain[0].pass.pneg  = s7_ff.dneg != s7_ff.gneg;
      chain[0].pass.gneg  = s7_ff.gneg;
      chain[0].pass.gzero = s7_ff.gzero;
      chain[0].pass.pzero = s7_ff.pzero;
      chain[0].pass.lzero = s7_ff.lzero;
      chain[0].pass.gl    = s7_ff.gl;
      chain[0].pass.glsat = s7_ff.glsat;
      chain[0].rem = s7_ff.n[63:33];
      chain[0].nb  = s7_ff.n[32:0];
      chain[0].quo = '0;
      chain[0].den = s7_ff.den;
      chain[0].ovf = s7_ff.n[63:33] >= s7_ff.den;
   end

   for (genvar k = 0; k < bce_pkg::QUO_BITS; k++) begin : g_div
      bce_div_cell u_cell (
         .clock(clock),
         .reset(reset),
         .d_in (chain[k]),
         .d_out(chain[k+1])
      );
   end

   assign div_out = chain[bce_pkg::QUO_BITS];

   // Final saturation; p=0 clips by sign, but g=0 zeroes both, t=0 grad_prob.
   always_comb begin
      gp_sat = sat(chain[bce_pkg::QUO_BITS].pass.pneg,
                   chain[bce_pkg::QUO_BITS].ovf ? 40'hFF_FFFF_FFFF
                                                 : 40'(chain[bce_pkg::QUO_BITS].quo));
      gp_fin = gp_sat[31:0];
      gl_fin = chain[bce_pkg::QUO_BITS].pass.gl;
      sat_fin = gp_sat[32] || chain[bce_pkg::QUO_BITS].pass.glsat;
      if (chain[bce_pkg::QUO_BITS].pass.pzero) begin
         sat_fin = 1'b1;
         if (chain[bce_pkg::QUO_BITS].pass.lzero || chain[bce_pkg::QUO_BITS].pass.gzero) begin
            gp_fin = 32'd0;
         end else begin
            gp_fin = chain[bce_pkg::QUO_BITS].pass.gneg ? 32'h7FFFFFFF : 32'h80000000;
         end
         if (chain[bce_pkg::QUO_BITS].pass.gzero) begin
            gl_fin = 32'd0;
         end else begin
            gl_fin = chain[bce_pkg::QUO_BITS].pass.gneg ? 32'h80000000 : 32'h7FFFFFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain[bce_pkg::QUO_BITS].pass.valid;
      end
      gp_ff  <= gp_fin;
      gl_ff  <= gl_fin;
      sat_ff <= sat_fin;
   end

   assign busy = 1'b0;
   assign rsp_valid = out_valid_ff;
   assign rsp_grad_prob = gp_ff;
   assign rsp_grad_label = gl_ff;
   assign rsp_saturated = sat_ff;

   `BCE_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##LATENCY rsp_valid)
   `BCE_ASSERT_NEXT(a_pzero_flag, clock, reset, div_out.pass.valid && div_out.pass.pzero, rsp_saturated)
   `BCE_ASSERT_NEXT(a_gzero_out, clock, reset, div_out.pass.valid && div_out.pass.gzero, rsp_grad_prob == 32'sd0 && rsp_grad_label == 32'sd0)

endmodule

@@ hdl/bce_log2.sv @@
// Three-stage table-based log2 of a 17-bit integer in [1,65536], Q5.24 result.
module bce_log2 (
   input  logic        clock,
   input  logic [16:0] x,
   output logic [28:0] log_q24
);

   logic [4:0] e;
   logic [16:0] norm;
   logic [15:0] frac;
   logic [16+bce_pkg::LOG_AW-1:0] s;
   logic [bce_pkg::LOG_AW-1:0] idx;
   logic [24:0] lo, hi;

   logic [4:0]  e1_ff, e2_ff;
   logic [24:0] lo1_ff, diff1_ff, lo2_ff;
   logic [15:0] r1_ff;
   logic [40:0] m2_ff;
   logic [28:0] log_ff;

   always_comb begin
      e = '0;
      for (int k = 0; k < 17; k++) begin
         if (x[k]) e = 5'(k);
      end
      norm = x << (5'd16 - e);
      frac = norm[15:0];
      s = (16 + bce_pkg::LOG_AW)'(frac) * (16 + bce_pkg::LOG_AW)'(bce_pkg::LOG_TABLE_SIZE);
      idx = s[16+bce_pkg::LOG_AW-1:16];
      lo = bce_pkg::LOG_TAB[idx];
      hi = bce_pkg::LOG_TAB[bce_pkg::LOG_AW'(idx + 1'b1)];
   end

   always_ff @(posedge clock) begin
      e1_ff    <= e;
      lo1_ff   <= lo;
      diff1_ff <= hi - lo;
      r1_ff    <= s[15:0];
      e2_ff    <= e1_ff;
      lo2_ff   <= lo1_ff;
      m2_ff    <= 41'(diff1_ff) * 41'(r1_ff);
      log_ff   <= (29'(e2_ff) << 24) + 29'(lo2_ff) + 29'((m2_ff + 41'd32768) >> 16);
   end

   assign log_q24 = log_ff;

endmodule

@@ hdl/bce_div_cell.sv @@
// One restoring-division step: a quotient bit per cell, passed to the next.
module bce_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bce_pkg::div_stage_type d_in,
   output bce_pkg::div_stage_type d_out
);

   logic [31:0] t;
   logic ge;
   bce_pkg::div_stage_type nxt_in, d_ff;

   always_comb begin
      t = {d_in.rem, d_in.nb[bce_pkg::QUO_BITS-1]};
      ge = t >= {1'b0, d_in.den};
      nxt_in = d_in;
      nxt_in.rem = ge ? 31'(t - {1'b0, d_in.den}) : t[30:0];
      nxt_in.nb = {d_in.nb[bce_pkg::QUO_BITS-2:0], 1'b0};
      nxt_in.quo = {d_in.quo[bce_pkg::QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.pass.valid <= 1'b0;
      end else begin
         d_ff <= nxt_in;
      end
   end

   assign d_out = d_ff;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of the binary cross-entropy gradient pipeline.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of random transactions sent after the directed cases.
   localparam int RANDOM_ITEMS = 1100;
   // Cycles in which no transaction is accepted or returned before the run is abandoned.
   localparam int STALL_LIMIT = 2000;
   // Cycles waited at the end, longer than the latency of the pipeline.
   localparam int DRAIN_CYCLES = 60;
   localparam logic [63:0] ONE_Q24 = 64'd16777216;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic        [15:0] req_prob;
   logic        [15:0] req_label;
   logic signed [31:0] req_upstream_grad;
   logic               rsp_valid;
   logic signed [31:0] rsp_grad_prob;
   logic signed [31:0] rsp_grad_label;
   logic               rsp_saturated;

   // One predicted gradient result.
   typedef struct packed {
      logic [31:0] grad_prob;
      logic [31:0] grad_label;
      logic        sat;
   } grad_result_type;

   grad_result_type pending_grads[$];
   logic [31:0]  log2_tab [0:bce_pkg::LOG_TABLE_SIZE];
   int           error_count;
   int           sent_count;
   int           checked_count;
   int           idle_cycles;
   int           sat_seen;

   binary_cross_entropy_gradient dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_prob          (req_prob),
      .req_label         (req_label),
      .req_upstream_grad (req_upstream_grad),
      .rsp_valid         (rsp_valid),
      .rsp_grad_prob     (rsp_grad_prob),
      .rsp_grad_label    (rsp_grad_label),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The log2 table is rebuilt here by repeated squaring, so that the
   // prediction does not lean on the package's own function.
   initial begin
      logic [63:0] y;
      logic [31:0] acc;
      for (int i = 0; i < bce_pkg::LOG_TABLE_SIZE; i++) begin
         y = ((64'(bce_pkg::LOG_TABLE_SIZE) + 64'(i)) << 30) / 64'(bce_pkg::LOG_TABLE_SIZE);
         acc = '0;
         for (int b = 0; b < 24; b++) begin
            y = (y * y) >> 30;
            acc = acc << 1;
            if (y >= 64'h8000_0000) begin
               acc = acc | 32'd1;
               y = y >> 1;
            end
         end
         log2_tab[i] = acc;
      end
      log2_tab[bce_pkg::LOG_TABLE_SIZE] = 32'(ONE_Q24);
   end

   // Base-2 logarithm of x in [1, 65536], in Q40.24, interpolated from the table.
   function automatic logic [63:0] log2_fixed(input logic [31:0] x);
      logic [31:0] expo;
      logic [31:0] frac;
      logic [63:0] scaled;
      logic [31:0] idx;
      logic [63:0] weight;
      logic [63:0] lo;
      logic [63:0] hi;
      expo = 0;
      for (int k = 0; k <= 16; k++)
         if (x >> k > 1) expo = k + 1;
      frac = (x << (16 - expo)) & 32'hFFFF;
      scaled = 64'(frac) * 64'(bce_pkg::LOG_TABLE_SIZE);
      idx = 32'(scaled >> 16);
      if (idx >= bce_pkg::LOG_TABLE_SIZE) idx = bce_pkg::LOG_TABLE_SIZE - 1;
      weight = scaled & 64'hFFFF;
      lo = 64'(log2_tab[idx]);
      hi = 64'(log2_tab[idx + 1]);
      return 64'(expo) * ONE_Q24 + lo + (((hi - lo) * weight + 64'd32768) >> 16);
   endfunction

   // Clips a sign and magnitude to the signed 32-bit range.
   function automatic logic [31:0] clip_signed(input logic neg, input logic [63:0] mag,
                                               inout logic sat);
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
   endfunction

   // Computes both gradients and the saturation flag of one element.
   function automatic grad_result_type predict_grads(input logic [15:0] p,
                                                     input logic [15:0] t,
                                                     input logic [31:0] g);
      grad_result_type res;
      logic         gneg;
      logic [63:0]  gmag;
      logic [31:0]  q;
      logic         dneg;
      logic [63:0]  dmag;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  lq;
      logic [63:0]  lp;
      logic         lneg;
      logic [63:0]  lmag;
      logic [127:0] nat;
      logic [127:0] prod;
      logic         sat;
      gneg = g[31];
      gmag = gneg ? (64'h1_0000_0000 - 64'(g)) : 64'(g);
      sat = 1'b0;
      if (p == 0) begin
         // A zero prediction always saturates; a zero g zeroes both gradients and a zero t zeroes grad_prob.
         sat = 1'b1;
         if (t == 0 || gmag == 0) res.grad_prob = '0;
         else res.grad_prob = clip_signed(!gneg, 64'hFF_FFFF_FFFF, sat);
         if (gmag == 0) res.grad_label = '0;
         else res.grad_label = clip_signed(gneg, 64'hFF_FFFF_FFFF, sat);
      end else begin
         q = 32'd65536 - 32'(p);
         dneg = t > p;
         dmag = dneg ? 64'(t - p) : 64'(p - t);
         num = (dmag << 16) * gmag;
         den = 64'(p) * 64'(q);
         lq = log2_fixed(q);
         lp = log2_fixed(32'(p));
         lneg = lp > lq;
         lmag = lneg ? lp - lq : lq - lp;
         nat = ((128'(lmag) * 128'(bce_pkg::LN2_Q32)) + (128'd1 << 31)) >> 32;
         prod = nat * 128'(gmag);
         res.grad_prob = clip_signed(dneg != gneg, (num + den / 2) / den, sat);
         res.grad_label = clip_signed(lneg != gneg, 64'((prod + (128'd1 << 23)) >> 24), sat);
      end
      res.sat = sat;
      return res;
   endfunction

   // Sends one transaction after a random gap (none with no_gap) and records its prediction.
   // start stays high afterwards so that back-to-back calls leave no gap.
   task automatic send_element(input logic [15:0] p, input logic [15:0] t,
                               input logic [31:0] g, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_prob <= p;
      req_label <= t;
      req_upstream_grad <= g;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_grads.push_back(predict_grads(p, t, g));
      sent_count++;
   endtask

   // Stops sending and waits until every predicted result has been checked.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_grads.size() != 0) @(posedge clock);
   endtask

   // Corners of all three fields, including the zero-prediction cases.
   task automatic test_directed_corners();
      send_element(16'd0, 16'd0, 32'h0001_0000);
      send_element(16'd0, 16'd1234, 32'h0001_0000);
      send_element(16'd0, 16'd1234, 32'hFFFF_0000);
      send_element(16'd0, 16'd1234, 32'd0);
      send_element(16'd0, 16'hFFFF, 32'h8000_0000);
      send_element(16'd1, 16'hFFFF, 32'h7FFF_FFFF);
      send_element(16'd1, 16'd0, 32'h0000_0001);
      send_element(16'hFFFF, 16'd0, 32'h0001_0000);
      send_element(16'hFFFF, 16'hFFFF, 32'h8000_0000);
      send_element(16'h8000, 16'h8000, 32'h0001_0000);
      send_element(16'h8000, 16'd0, 32'h8000_0000);
      send_element(16'h8000, 16'hFFFF, 32'h7FFF_FFFF);
      send_element(16'h4000, 16'hC000, 32'hFFFF_FFFF);
      send_element(16'hC000, 16'h4000, 32'h0000_0001);
      send_element(16'd2, 16'h0001, 32'h0100_0000);
      send_element(16'hFFFE, 16'hFFFF, 32'hFF00_0000);
      send_element(16'h0100, 16'h0100, 32'd0);
   endtask

   // Random elements; mostly modest gradients so the results stay in range,
   // with full-range values and zero predictions mixed in.
   task automatic test_random_elements();
      logic [15:0] p;
      logic [15:0] t;
      logic [31:0] g;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(9))
            0: p = 16'd0;
            1: p = 16'($urandom_range(8));
            2: p = 16'hFFFF - 16'($urandom_range(8));
            default: p = 16'($urandom);
         endcase
         t = ($urandom_range(3) == 0) ? 16'($urandom_range(1) ? 16'hFFFF : 0) : 16'($urandom);
         case ($urandom_range(3))
            0: g = $urandom;
            1: g = 32'($signed(16'($urandom)));
            default: g = 32'($signed(20'($urandom)));
         endcase
         // Some bursts run back to back with no gap at all.
         send_element(p, t, g, n % 200 < 40);
         // The sender once holds off until the pipeline has emptied.
         if (n == RANDOM_ITEMS / 2) wait_drained();
      end
   endtask

   // Compares each strobed result with the oldest prediction.
   always @(posedge clock) begin
      grad_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_grads.size() == 0) begin
            $display("%0t: unexpected result %h %h %b", $time, rsp_grad_prob,
                     rsp_grad_label, rsp_saturated);
            error_count++;
         end else begin
            exp_res = pending_grads.pop_front();
            checked_count++;
            if (rsp_saturated) sat_seen++;
            if (rsp_grad_prob !== exp_res.grad_prob) begin
               $display("%0t: grad_prob expected %h actual %h", $time,
                        exp_res.grad_prob, rsp_grad_prob);
               error_count++;
            end
            if (rsp_grad_label !== exp_res.grad_label) begin
               $display("%0t: grad_label expected %h actual %h", $time,
                        exp_res.grad_label, rsp_grad_label);
               error_count++;
            end
            if (rsp_saturated !== exp_res.sat) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        exp_res.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      idle_cycles = 0;
      sat_seen = 0;
      reset = 1'b1;
      start = 1'b0;
      req_prob = '0;
      req_label = '0;
      req_upstream_grad = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_elements();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d elements, checked %0d results, %0d of them saturated.",
               sent_count, checked_count, sat_seen);
      if (error_count == 0 && pending_grads.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
